FILE: design/scf_pkg.sv
// Package for the sliding cubic fit velocity block: widths, register map and tap generation.
`timescale 1ns / 1ps

package scf_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int POS_W           = 48;
    localparam int VEL_W           = 64;
    localparam int POS_FRAC_BITS   = 16;
    localparam int RATE_W          = 32;
    localparam int PDATA_W         = 32;
    localparam int PADDR_W         = 1;
    // Integer bits (with sign) that every quantized tap needs.
    localparam int TAP_INT_BITS    = 4;

    localparam logic [PADDR_W-1:0] REG_SAMPLE_RATE = 1'b0;
    localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = 32'd6553600;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [POS_W-1:0]    t_pos;
    typedef logic signed [VEL_W-1:0]    t_vel;
    typedef logic [RATE_W-1:0]          t_rate;

    // num/den rounded to f fraction bits, to nearest, ties away from zero.
    // Built as a shift-subtract long division; only evaluated at elaboration.
    function automatic longint round_frac(longint num, longint den, int f);
        longint unsigned m;
        longint unsigned d;
        longint unsigned q;
        longint unsigned r;
        bit              neg;
        int              k;
        if (den <= 0) begin
            return 0;
        end
        neg = (num < 0);
        m   = neg ? longint'(64'd0 - num) : num;
        d   = den;
        q   = 0;
        r   = 0;
        for (k = 63; k >= 0; k--) begin
            r = (r << 1) | longint'(m[k]);
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        for (k = 0; k < f; k++) begin
            q = q << 1;
            r = r << 1;
            if (r >= d) begin
                r = r - d;
                q = q + 64'd1;
            end
        end
        if (r >= d - r) begin
            q = q + 64'd1;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Tap for window slot i (0 = oldest) of an n-sample cubic fit, position or velocity.
    function automatic longint fit_tap(int n, int f, int i, bit vel);
        longint s0;
        longint s2;
        longint s4;
        longint s6;
        longint d_even;
        longint d_odd;
        longint uu;
        longint u;
        longint u2;
        longint u3;
        longint ev0;
        longint ev2;
        longint od1;
        longint od3;
        int     j;
        s0 = 0;
        s2 = 0;
        s4 = 0;
        s6 = 0;
        uu = n - 1;
        for (j = 0; j < n; j++) begin
            u  = 2 * longint'(j) - (n - 1);
            u2 = u * u;
            s0 = s0 + 1;
            s2 = s2 + u2;
            s4 = s4 + u2 * u2;
            s6 = s6 + u2 * u2 * u2;
        end
        d_even = s0 * s4 - s2 * s2;
        d_odd  = s2 * s6 - s4 * s4;
        u   = 2 * longint'(i) - (n - 1);
        u2  = u * u;
        u3  = u2 * u;
        ev0 = s4 - s2 * u2;
        ev2 = s0 * u2 - s2;
        od1 = s6 * u - s4 * u3;
        od3 = s2 * u3 - s4 * u;
        if (vel) begin
            return round_frac(4 * uu * ev2, d_even, f)
                 + round_frac(2 * od1 + 6 * uu * uu * od3, d_odd, f);
        end
        return round_frac(ev0 + uu * uu * ev2, d_even, f)
             + round_frac(uu * od1 + uu * uu * uu * od3, d_odd, f);
    endfunction

endpackage

FILE: design/scf_in_if.sv
// Input channel: one position sample per beat.
`timescale 1ns / 1ps

interface scf_in_if;
    logic              valid;
    logic              ready;
    scf_pkg::t_sample  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: design/scf_out_if.sv
// Output channel: fitted position and velocity per beat.
`timescale 1ns / 1ps

interface scf_out_if;
    logic           valid;
    logic           ready;
    scf_pkg::t_pos  position_estimate;
    scf_pkg::t_vel  velocity_estimate;

    modport source (output valid, output position_estimate, output velocity_estimate,
                    input ready);
    modport sink   (input valid, input position_estimate, input velocity_estimate,
                    output ready);
endinterface

FILE: design/scf_cell.sv
// One tap cell of the transposed FIR chain: multiplies the sample and adds its neighbor's sum.
`timescale 1ns / 1ps

module scf_cell #(
    parameter int                      TAP_W   = 28,
    parameter int                      ACC_W   = 64,
    parameter logic signed [TAP_W-1:0] POS_TAP = '0,
    parameter logic signed [TAP_W-1:0] VEL_TAP = '0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  scf_pkg::t_sample        i_sample,
    input  logic signed [ACC_W-1:0] i_pos_sum,
    input  logic signed [ACC_W-1:0] i_vel_sum,
    output logic signed [ACC_W-1:0] o_pos_sum,
    output logic signed [ACC_W-1:0] o_vel_sum
);

    localparam int MUL_W = TAP_W + scf_pkg::SAMPLE_W;

    logic signed [MUL_W-1:0] w_pos_mul;
    logic signed [MUL_W-1:0] w_vel_mul;
    logic signed [ACC_W-1:0] r_pos_sum;
    logic signed [ACC_W-1:0] r_vel_sum;
    logic signed [ACC_W-1:0] n_pos_sum;
    logic signed [ACC_W-1:0] n_vel_sum;

    assign w_pos_mul = POS_TAP * i_sample;
    assign w_vel_mul = VEL_TAP * i_sample;
    assign n_pos_sum = {{(ACC_W-MUL_W){w_pos_mul[MUL_W-1]}}, w_pos_mul} + i_pos_sum;
    assign n_vel_sum = {{(ACC_W-MUL_W){w_vel_mul[MUL_W-1]}}, w_vel_mul} + i_vel_sum;

    // The partial sums stand for the window contents, so they clear with it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_sum <= '0;
            r_vel_sum <= '0;
        end else if (i_en) begin
            r_pos_sum <= n_pos_sum;
            r_vel_sum <= n_vel_sum;
        end
    end

    assign o_pos_sum = r_pos_sum;
    assign o_vel_sum = r_vel_sum;

endmodule

FILE: design/scf_post.sv
// Output stage: scales velocity by the sample rate chunk by chunk, saturates, holds the result.
`timescale 1ns / 1ps

module scf_post #(
    parameter int ACC_W         = 64,
    parameter int TAP_FRAC_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_pos_acc,
    input  logic signed [ACC_W-1:0] i_vel_acc,
    input  scf_pkg::t_rate          i_rate,
    output logic                    o_idle,
    scf_out_if.source               o_out
);

    localparam int NCH   = (ACC_W + 31) / 32;
    localparam int EXT_W = NCH * 32;
    localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PRD_W = 66;
    localparam int VP_W  = EXT_W + 34;
    localparam int POS_SHIFT = TAP_FRAC_BITS - scf_pkg::POS_FRAC_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        n_cnt;
    logic signed [VP_W-1:0]  r_vprod;
    logic signed [VP_W-1:0]  n_vprod;
    logic                    r_out_valid;
    logic                    n_out_valid;
    scf_pkg::t_pos           r_pos;
    scf_pkg::t_vel           r_vel;

    logic [EXT_W-1:0]        w_ext;
    logic [31:0]             w_chunk;
    logic                    w_last;
    logic signed [32:0]      w_op_a;
    logic signed [32:0]      w_op_b;
    logic signed [PRD_W-1:0] w_prod;
    logic signed [VP_W-1:0]  w_term;
    logic signed [VP_W-1:0]  w_vsh;
    logic signed [ACC_W-1:0] w_psh;
    logic                    w_vfit;
    logic                    w_pfit;
    scf_pkg::t_pos           w_pos_sat;
    scf_pkg::t_vel           w_vel_sat;
    logic                    w_load;

    // Lower chunks are unsigned digits; the top chunk carries the sign.
    assign w_ext   = EXT_W'(i_vel_acc);
    assign w_chunk = w_ext[32*r_cnt +: 32];
    assign w_last  = (r_cnt == CNT_W'(NCH - 1));
    assign w_op_a  = {w_last ? w_chunk[31] : 1'b0, w_chunk};
    assign w_op_b  = {1'b0, i_rate};
    assign w_prod  = w_op_a * w_op_b;
    assign w_term  = {{(VP_W-PRD_W){w_prod[PRD_W-1]}}, w_prod} <<< {r_cnt, 5'b0};

    assign w_vsh  = r_vprod >>> TAP_FRAC_BITS;
    assign w_vfit = (&w_vsh[VP_W-1:scf_pkg::VEL_W-1]) | ~(|w_vsh[VP_W-1:scf_pkg::VEL_W-1]);
    assign w_vel_sat = w_vfit ? w_vsh[scf_pkg::VEL_W-1:0]
                     : {w_vsh[VP_W-1], {(scf_pkg::VEL_W-1){~w_vsh[VP_W-1]}}};

    assign w_psh  = i_pos_acc >>> POS_SHIFT;
    assign w_pfit = (&w_psh[ACC_W-1:scf_pkg::POS_W-1]) | ~(|w_psh[ACC_W-1:scf_pkg::POS_W-1]);
    assign w_pos_sat = w_pfit ? w_psh[scf_pkg::POS_W-1:0]
                     : {w_psh[ACC_W-1], {(scf_pkg::POS_W-1){~w_psh[ACC_W-1]}}};

    assign w_load = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_vprod     = r_vprod;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_MAC;
                    n_cnt   = '0;
                    n_vprod = '0;
                end
            end
            ST_MAC: begin
                n_vprod = r_vprod + w_term;
                if (w_last) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FIN: begin
                if (w_load) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vprod <= n_vprod;
        if (w_load) begin
            r_pos <= w_pos_sat;
            r_vel <= w_vel_sat;
        end
    end

    assign o_idle                  = (r_state == ST_IDLE);
    assign o_out.valid             = r_out_valid;
    assign o_out.position_estimate = r_pos;
    assign o_out.velocity_estimate = r_vel;

endmodule

FILE: design/sliding_cubic_fit_velocity.sv
// Top level of the sliding cubic fit position and velocity estimator.
`timescale 1ns / 1ps

// Each input beat carries one encoder position sample. A least-squares cubic is fitted over
// the latest WIN_LEN samples (zeros after reset count as samples until the window fills)
// and evaluated at the newest one; the output beat carries the fitted position (Q.16) and the
// fitted velocity in ticks per second (Q.16, scaled by the sample_rate register, Q16.16 at
// byte address 0). Both saturate. The fit is a transposed FIR chain with one cell per window
// slot, whose taps are fixed at build time with TAP_FRAC_BITS fraction bits. The velocity
// accumulator is multiplied by the rate one 32-bit chunk per cycle, and no new sample is
// accepted until the result is loaded. A finished result waits in an output register while
// the next sample is accepted.
module sliding_cubic_fit_velocity #(
    parameter int WIN_LEN       = 16,
    parameter int TAP_FRAC_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [scf_pkg::PADDR_W-1:0]     paddr,
    input  logic [scf_pkg::PDATA_W-1:0]     pwdata,
    output logic [scf_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    scf_in_if.sink                          i_in,
    scf_out_if.source                       o_out
);

    localparam int TAP_W = TAP_FRAC_BITS + scf_pkg::TAP_INT_BITS;
    localparam int ACC_W = TAP_W + scf_pkg::SAMPLE_W + $clog2(WIN_LEN);

    scf_pkg::t_rate          r_rate;
    logic                    w_accept;
    logic                    w_idle;
    logic signed [ACC_W-1:0] w_pos_sum [0:WIN_LEN];
    logic signed [ACC_W-1:0] w_vel_sum [0:WIN_LEN];

    assign pready = 1'b1;
    assign prdata = (paddr == scf_pkg::REG_SAMPLE_RATE) ? r_rate : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= scf_pkg::SAMPLE_RATE_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr == scf_pkg::REG_SAMPLE_RATE) begin
            r_rate <= pwdata;
        end
    end

    assign i_in.ready = w_idle;
    assign w_accept   = i_in.valid && w_idle;

    // Cell j sees the sample j beats old; the far end of the chain starts from zero.
    assign w_pos_sum[WIN_LEN] = '0;
    assign w_vel_sum[WIN_LEN] = '0;

    for (genvar j = 0; j < WIN_LEN; j++) begin : g_cell
        localparam logic signed [TAP_W-1:0] POS_TAP =
            TAP_W'(scf_pkg::fit_tap(WIN_LEN, TAP_FRAC_BITS, WIN_LEN - 1 - j, 1'b0));
        localparam logic signed [TAP_W-1:0] VEL_TAP =
            TAP_W'(scf_pkg::fit_tap(WIN_LEN, TAP_FRAC_BITS, WIN_LEN - 1 - j, 1'b1));

        scf_cell #(
            .TAP_W   (TAP_W),
            .ACC_W   (ACC_W),
            .POS_TAP (POS_TAP),
            .VEL_TAP (VEL_TAP)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_accept),
            .i_sample  (i_in.sample),
            .i_pos_sum (w_pos_sum[j+1]),
            .i_vel_sum (w_vel_sum[j+1]),
            .o_pos_sum (w_pos_sum[j]),
            .o_vel_sum (w_vel_sum[j])
        );
    end

    scf_post #(
        .ACC_W         (ACC_W),
        .TAP_FRAC_BITS (TAP_FRAC_BITS)
    ) u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_pos_acc (w_pos_sum[0]),
        .i_vel_acc (w_vel_sum[0]),
        .i_rate    (r_rate),
        .o_idle    (w_idle),
        .o_out     (o_out)
    );

endmodule
